[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the autocrop block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Antecedent holds at a clock edge -> consequent holds at the same edge.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent holds at a clock edge -> consequent holds at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/cbb_pkg.sv]
// Package with shared types, codes and helpers of the autocrop block.
`default_nettype none
package cbb_pkg;

    localparam int PIX_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int OUT_DATA_W = 72;

    localparam logic [7:0] WHITE_LEVEL = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    // geometry and flags of one read result
    typedef struct packed {
        logic       empty;
        logic       last;
        logic [7:0] left;
        logic [7:0] top;
        logic [8:0] width;
        logic [8:0] height;
    } t_rd_meta;

    // byte mask for the configured channel count; 0 acts as 1, above 4 as 4
    function automatic logic [PIX_W-1:0] f_pixel_mask(input logic [2:0] cc);
        logic [PIX_W-1:0] m;
        case (cc) inside
            3'd0, 3'd1: m = 32'h0000_00FF;
            3'd2:       m = 32'h0000_FFFF;
            3'd3:       m = 32'h00FF_FFFF;
            default:    m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

[hdl/cbb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module cbb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[hdl/cbb_load.sv]
// Load side: raster position of incoming pixels and content bounding box.
`default_nettype none
module cbb_load #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic [7:0]                    i_pix_lo,
    input  wire logic [$clog2(MAX_WIDTH):0]    i_ew,
    input  wire logic [$clog2(MAX_HEIGHT):0]   i_eh,
    output logic      [$clog2(MAX_WIDTH)-1:0]  o_wcol,
    output logic      [$clog2(MAX_HEIGHT)-1:0] o_wrow,
    output logic                               o_clear,
    output logic      [$clog2(MAX_WIDTH)-1:0]  o_min_col,
    output logic      [$clog2(MAX_WIDTH)-1:0]  o_max_col,
    output logic      [$clog2(MAX_HEIGHT)-1:0] o_min_row,
    output logic      [$clog2(MAX_HEIGHT)-1:0] o_max_row,
    output logic                               o_found
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [CW-1:0] MIN_COL_RST = CW'(MAX_WIDTH - 1);
    localparam logic [RW-1:0] MIN_ROW_RST = RW'(MAX_HEIGHT - 1);

    logic [CW-1:0] r_col, n_col, r_min_col, n_min_col, r_max_col, n_max_col;
    logic [RW-1:0] r_row, n_row, r_min_row, n_min_row, r_max_row, n_max_row;
    logic          r_found, n_found;
    logic [CW:0]   c1, c2;
    logic [RW:0]   r1, r2;
    logic          origin;

    always_comb begin
        // wrap a position left stale by a geometry change
        c1 = {1'b0, r_col};
        r1 = {1'b0, r_row};
        if (c1 >= i_ew) begin
            c1 = '0;
            r1 = r1 + 1'b1;
        end
        if (r1 >= i_eh) begin
            r1 = '0;
        end
        origin = (c1 == '0) && (r1 == '0);

        // frame origin starts a fresh box
        n_min_col = origin ? MIN_COL_RST : r_min_col;
        n_max_col = origin ? '0 : r_max_col;
        n_min_row = origin ? MIN_ROW_RST : r_min_row;
        n_max_row = origin ? '0 : r_max_row;
        n_found   = origin ? 1'b0 : r_found;
        if (i_pix_lo != cbb_pkg::WHITE_LEVEL) begin
            if (c1[CW-1:0] < n_min_col) n_min_col = c1[CW-1:0];
            if (c1[CW-1:0] > n_max_col) n_max_col = c1[CW-1:0];
            if (r1[RW-1:0] < n_min_row) n_min_row = r1[RW-1:0];
            if (r1[RW-1:0] > n_max_row) n_max_row = r1[RW-1:0];
            n_found = 1'b1;
        end

        c2 = c1 + 1'b1;
        r2 = r1;
        if (c2 >= i_ew) begin
            c2 = '0;
            r2 = r1 + 1'b1;
            if (r2 >= i_eh) begin
                r2 = '0;
            end
        end
        n_col = c2[CW-1:0];
        n_row = r2[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_min_col <= MIN_COL_RST;
            r_max_col <= '0;
            r_min_row <= MIN_ROW_RST;
            r_max_row <= '0;
            r_found   <= 1'b0;
        end else if (i_load) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_min_col <= n_min_col;
            r_max_col <= n_max_col;
            r_min_row <= n_min_row;
            r_max_row <= n_max_row;
            r_found   <= n_found;
        end
    end

    assign o_wcol    = c1[CW-1:0];
    assign o_wrow    = r1[RW-1:0];
    assign o_clear   = i_load && origin;
    assign o_min_col = r_min_col;
    assign o_max_col = r_max_col;
    assign o_min_row = r_min_row;
    assign o_max_row = r_max_row;
    assign o_found   = r_found;

endmodule
`default_nettype wire

[hdl/cbb_read.sv]
// Read side: crop walk, frame-store read issue, read stage and output register.
`default_nettype none
module cbb_read #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_read,
    input  wire logic                                    i_clear,
    input  wire logic                                    i_found,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]            i_min_col,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]            i_max_col,
    input  wire logic [$clog2(MAX_HEIGHT)-1:0]           i_min_row,
    input  wire logic [$clog2(MAX_HEIGHT)-1:0]           i_max_row,
    input  wire logic [cbb_pkg::PIX_W-1:0]               i_mask,
    output logic      [$clog2(MAX_WIDTH)-1:0]            o_rcol,
    output logic      [$clog2(MAX_HEIGHT)-1:0]           o_rrow,
    input  wire logic [cbb_pkg::PIX_W-1:0]               i_rdata,
    output logic                                         o_ready,
    output logic                                         o_valid,
    input  wire logic                                    i_ready,
    output logic      [cbb_pkg::PIX_W-1:0]               o_pixel,
    output cbb_pkg::t_rd_meta                            o_meta
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] r_pos_col, n_pos_col;
    logic [RW-1:0] r_pos_row, n_pos_row;
    logic [CW:0]   bw, rc1, rc2;
    logic [RW:0]   bh, rr1, rr2;
    cbb_pkg::t_rd_meta n_meta, r_p1_meta, r_out_meta;
    logic          r_p1_vld, r_out_vld, move;
    logic [cbb_pkg::PIX_W-1:0] r_out_pix;

    always_comb begin
        bw  = {1'b0, i_max_col} - {1'b0, i_min_col} + 1'b1;
        bh  = {1'b0, i_max_row} - {1'b0, i_min_row} + 1'b1;
        rc1 = {1'b0, r_pos_col};
        rr1 = {1'b0, r_pos_row};
        if (rc1 >= bw) begin
            rc1 = '0;
            rr1 = rr1 + 1'b1;
        end
        if (rr1 >= bh) begin
            rr1 = '0;
        end
        rc2 = rc1 + 1'b1;
        rr2 = rr1;
        if (rc2 >= bw) begin
            rc2 = '0;
            rr2 = rr1 + 1'b1;
            if (rr2 >= bh) begin
                rr2 = '0;
            end
        end
        n_pos_col = rc2[CW-1:0];
        n_pos_row = rr2[RW-1:0];

        n_meta.empty  = !i_found;
        n_meta.last   = !i_found || ((rc1 == bw - 1'b1) && (rr1 == bh - 1'b1));
        n_meta.left   = i_found ? 8'(i_min_col) : 8'd0;
        n_meta.top    = i_found ? 8'(i_min_row) : 8'd0;
        n_meta.width  = i_found ? 9'(bw) : 9'd0;
        n_meta.height = i_found ? 9'(bh) : 9'd0;
    end

    assign o_rcol  = i_min_col + rc1[CW-1:0];
    assign o_rrow  = i_min_row + rr1[RW-1:0];

    assign move    = r_p1_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_p1_vld || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_col <= '0;
            r_pos_row <= '0;
            r_p1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_clear) begin
                r_pos_col <= '0;
                r_pos_row <= '0;
            end else if (i_read && i_found) begin
                r_pos_col <= n_pos_col;
                r_pos_row <= n_pos_row;
            end
            if (i_read) begin
                r_p1_vld <= 1'b1;
            end else if (move) begin
                r_p1_vld <= 1'b0;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_read) begin
            r_p1_meta <= n_meta;
        end
        if (move) begin
            r_out_meta <= r_p1_meta;
            r_out_pix  <= r_p1_meta.empty ? '0 : (i_rdata & i_mask);
        end
    end

    assign o_valid = r_out_vld;
    assign o_pixel = r_out_pix;
    assign o_meta  = r_out_meta;

endmodule
`default_nettype wire

[hdl/content_bounding_box_autocrop_core.sv]
// Autocrop top level: loads a frame into a frame store and streams out its content box.
// Throughput: one transfer (load or read) per cycle; under output stall one more read is
// taken into the read stage, then the input stalls for both kinds.
// A load takes effect at its transfer edge; a read result is registered by the frame-store read
// (read stage), then by the output register, and only then presented to the receiver.
// Reset (synchronous, active low) clears load/read positions, box, flags and config to
// 256 x 256 x 3 channels; the frame store itself is not cleared and needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module content_bounding_box_autocrop_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write port
    input  wire logic                              i_cfg_we,
    input  wire logic [cbb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [cbb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // command stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [cbb_pkg::PIX_W-1:0]         s_axis_tdata,  // [31:0] pixel_in
    input  wire logic [0:0]                        s_axis_tuser,  // [0] command
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [31:0] pixel_out, [39:32] box_left, [47:40] box_top,
    // [56:48] box_width, [65:57] box_height, [71:66] zero
    output logic      [cbb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                                   m_axis_tlast,  // last_of_crop
    output logic      [0:0]                        m_axis_tuser   // [0] empty_frame
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 2 ** AW;

    // clamp width/height registers into 1..MAX
    function automatic logic [CW:0] f_clamp_w(input logic [cbb_pkg::CFG_DATA_W-1:0] v);
        logic [CW:0] r;
        if (v == '0)                   r = (CW+1)'(1);
        else if (32'(v) > MAX_WIDTH)   r = (CW+1)'(MAX_WIDTH);
        else                           r = (CW+1)'(v);
        return r;
    endfunction

    function automatic logic [RW:0] f_clamp_h(input logic [cbb_pkg::CFG_DATA_W-1:0] v);
        logic [RW:0] r;
        if (v == '0)                   r = (RW+1)'(1);
        else if (32'(v) > MAX_HEIGHT)  r = (RW+1)'(MAX_HEIGHT);
        else                           r = (RW+1)'(v);
        return r;
    endfunction

    // config holds clamped values so the datapath never sees out-of-range geometry
    logic [CW:0]                r_ew;
    logic [RW:0]                r_eh;
    logic [cbb_pkg::PIX_W-1:0]  r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ew   <= f_clamp_w(9'd256);
            r_eh   <= f_clamp_h(9'd256);
            r_mask <= cbb_pkg::f_pixel_mask(3'd3);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cbb_pkg::CFG_IMAGE_WIDTH:   r_ew   <= f_clamp_w(i_cfg_data);
                cbb_pkg::CFG_IMAGE_HEIGHT:  r_eh   <= f_clamp_h(i_cfg_data);
                cbb_pkg::CFG_CHANNEL_COUNT: r_mask <= cbb_pkg::f_pixel_mask(i_cfg_data[2:0]);
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // command decode; tready comes from the read pipeline so both kinds share one gate
    logic w_accept, w_load, w_read;
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_load   = w_accept && (s_axis_tuser[0] == cbb_pkg::CMD_LOAD);
    assign w_read   = w_accept && (s_axis_tuser[0] == cbb_pkg::CMD_READ);

    logic [CW-1:0] w_wcol, w_min_col, w_max_col, w_rcol;
    logic [RW-1:0] w_wrow, w_min_row, w_max_row, w_rrow;
    logic          w_clear, w_found;
    logic [cbb_pkg::PIX_W-1:0] w_rdata, w_pixel;
    cbb_pkg::t_rd_meta         w_meta;

    // load side: position tracking and box growth, one pixel per cycle while tready is high
    cbb_load #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_load (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_pix_lo  (s_axis_tdata[7:0]),
        .i_ew      (r_ew),
        .i_eh      (r_eh),
        .o_wcol    (w_wcol),
        .o_wrow    (w_wrow),
        .o_clear   (w_clear),
        .o_min_col (w_min_col),
        .o_max_col (w_max_col),
        .o_min_row (w_min_row),
        .o_max_row (w_max_row),
        .o_found   (w_found)
    );

    // frame store, row-major with a power-of-two row pitch; a load written at one
    // edge is visible to a read transferred at any later edge
    cbb_ram #(
        .WIDTH (cbb_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr ({w_wrow, w_wcol}),
        .i_wdata (s_axis_tdata),
        .i_re    (w_read),
        .i_raddr ({w_rrow, w_rcol}),
        .o_rdata (w_rdata)
    );

    // read side: crop walk, read stage, output register
    cbb_read #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_read (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_read    (w_read),
        .i_clear   (w_clear),
        .i_found   (w_found),
        .i_min_col (w_min_col),
        .i_max_col (w_max_col),
        .i_min_row (w_min_row),
        .i_max_row (w_max_row),
        .i_mask    (r_mask),
        .o_rcol    (w_rcol),
        .o_rrow    (w_rrow),
        .i_rdata   (w_rdata),
        .o_ready   (s_axis_tready),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_pixel   (w_pixel),
        .o_meta    (w_meta)
    );

    assign m_axis_tdata = {6'd0, w_meta.height, w_meta.width, w_meta.top, w_meta.left, w_pixel};
    assign m_axis_tlast = w_meta.last;
    assign m_axis_tuser = w_meta.empty;

    // an all-white answer is a single zero pixel marked last
    `ASSERT_IMPLY(a_empty_form, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && (m_axis_tdata == '0))
    // once content is seen the box is well ordered
    `ASSERT_IMPLY(a_box_order, i_clk, i_rst_n, w_found, (w_min_col <= w_max_col) && (w_min_row <= w_max_row))
    // every store write lands inside the configured frame
    `ASSERT_IMPLY(a_load_in_frame, i_clk, i_rst_n, w_load, ({1'b0, w_wcol} < r_ew) && ({1'b0, w_wrow} < r_eh))
    // a found box only disappears through a new frame origin
    `ASSERT_NEXT(a_found_sticky, i_clk, i_rst_n, w_found && !w_clear, w_found)

endmodule
`default_nettype wire

[tb/sv/content_bounding_box_autocrop_core_tb.sv]
// Self-checking testbench for the autocrop core: frame loads, crop reads, register settings.
module content_bounding_box_autocrop_core_tb;

    localparam int  RANDOM_ITEMS  = 100;  // size of the random part, in accepted transfers
    localparam int  GAP_PCT       = 8;    // idle chance per transfer / per cycle, in percent
    localparam int  HOLD_CYCLES   = 80;   // long receiver hold-off that backs up the block
    localparam int  SETTLE_CYCLES = 6;    // quiet time after the last result before register writes
    localparam int  CYCLE_LIMIT   = 500000;

    // one expected read result, field by field
    typedef struct packed {
        logic [31:0] pixel;
        logic        last;
        logic        empty;
        logic [7:0]  left;
        logic [7:0]  top;
        logic [8:0]  width;
        logic [8:0]  height;
    } t_crop_result;

    // Mirror of the crop engine: frame store, load/read positions and the content box.
    // Each accepted command is stepped here; reads queue the pixel they must return.
    class crop_scoreboard;
        localparam int MAX_COLS = 256;
        localparam int MAX_ROWS = 256;

        logic [8:0]   width_reg;
        logic [8:0]   height_reg;
        logic [2:0]   chan_reg;
        logic [31:0]  frame_mem [int];    // only entries loaded since reset
        int           ld_col, ld_row;
        int           min_col, max_col, min_row, max_row;
        int           rd_col, rd_row;
        bit           found_any;
        bit           frame_open;         // frame began at origin under current geometry
        bit           frame_ready;        // that frame is fully loaded
        t_crop_result pending [$];
        int           mismatches, checked, loads, reads, frames;

        function new();
            width_reg  = 9'd256;
            height_reg = 9'd256;
            chan_reg   = 3'd3;
            ld_col     = 0;
            ld_row     = 0;
            clear_box();
        endfunction

        function void clear_box();
            min_col     = MAX_COLS - 1;
            min_row     = MAX_ROWS - 1;
            max_col     = 0;
            max_row     = 0;
            found_any   = 1'b0;
            rd_col      = 0;
            rd_row      = 0;
            frame_ready = 1'b0;
        endfunction

        function int clamp_dim(int v, int top);
            return (v < 1) ? 1 : (v > top) ? top : v;
        endfunction

        function int eff_width();
            return clamp_dim(int'(width_reg), MAX_COLS);
        endfunction

        function int eff_height();
            return clamp_dim(int'(height_reg), MAX_ROWS);
        endfunction

        function logic [31:0] channel_mask();
            int c;
            c = (chan_reg < 1) ? 1 : int'(chan_reg);
            if (c >= 4) return '1;
            return (32'd1 << (8 * c)) - 32'd1;
        endfunction

        function bit at_origin();
            return ld_col == 0 && ld_row == 0;
        endfunction

        // store entries under the box are all written once a frame is complete;
        // an empty box touches no entry at all
        function bit read_safe();
            return frame_ready || !found_any;
        endfunction

        function int box_area();
            if (!found_any) return 1;
            return (max_col - min_col + 1) * (max_row - min_row + 1);
        endfunction

        function void note_config(logic [cbb_pkg::CFG_IDX_W-1:0] idx,
                                  logic [cbb_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                cbb_pkg::CFG_IMAGE_WIDTH: begin
                    width_reg  = value;
                    frame_open = 1'b0;
                end
                cbb_pkg::CFG_IMAGE_HEIGHT: begin
                    height_reg = value;
                    frame_open = 1'b0;
                end
                cbb_pkg::CFG_CHANNEL_COUNT: begin
                    chan_reg = value[2:0];
                end
                default: ;
            endcase
        endfunction

        function void note_command(cbb_pkg::t_cmd cmd, logic [31:0] px);
            int           ew, eh, bw, bh, key;
            t_crop_result r;
            ew = eff_width();
            eh = eff_height();
            if (cmd == cbb_pkg::CMD_LOAD) begin
                // position may sit outside a geometry that shrank mid-frame
                if (ld_col >= ew) begin
                    ld_col = 0;
                    ld_row++;
                end
                if (ld_row >= eh) ld_row = 0;
                if (at_origin()) begin
                    clear_box();
                    frame_open = 1'b1;
                end
                frame_mem[ld_row * MAX_COLS + ld_col] = px;
                if (px[7:0] != cbb_pkg::WHITE_LEVEL) begin
                    if (ld_col < min_col) min_col = ld_col;
                    if (ld_col > max_col) max_col = ld_col;
                    if (ld_row < min_row) min_row = ld_row;
                    if (ld_row > max_row) max_row = ld_row;
                    found_any = 1'b1;
                end
                ld_col++;
                if (ld_col >= ew) begin
                    ld_col = 0;
                    ld_row++;
                    if (ld_row >= eh) ld_row = 0;
                end
                if (at_origin() && frame_open) begin
                    frame_ready = 1'b1;
                    frames++;
                end
                loads++;
            end else begin
                r = '0;
                if (!found_any) begin
                    // all-white frame: flagged, zero geometry, position held
                    r.last  = 1'b1;
                    r.empty = 1'b1;
                end else begin
                    bw = max_col - min_col + 1;
                    bh = max_row - min_row + 1;
                    if (rd_col >= bw) begin
                        rd_col = 0;
                        rd_row++;
                    end
                    if (rd_row >= bh) rd_row = 0;
                    key = (min_row + rd_row) * MAX_COLS + (min_col + rd_col);
                    r.pixel  = (frame_mem.exists(key) ? frame_mem[key] : 32'd0) & channel_mask();
                    r.last   = (rd_col == bw - 1) && (rd_row == bh - 1);
                    r.left   = 8'(min_col);
                    r.top    = 8'(min_row);
                    r.width  = 9'(bw);
                    r.height = 9'(bh);
                    rd_col++;
                    if (rd_col >= bw) begin
                        rd_col = 0;
                        rd_row++;
                        if (rd_row >= bh) rd_row = 0;
                    end
                end
                pending = {pending, r};
                reads++;
            end
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            $display("mismatch in %s at result %0d: got 'h%0h, want 'h%0h",
                     field, checked, got, want);
            mismatches++;
        endtask

        task check_output(logic [cbb_pkg::OUT_DATA_W-1:0] data, logic last, logic empty);
            t_crop_result e;
            if (pending.size() == 0) begin
                report("unrequested result", 64'(data[31:0]), 64'd0);
            end else begin
                e = pending.pop_front();
                checked++;
                if (data[31:0] !== e.pixel)  report("pixel_out", 64'(data[31:0]), 64'(e.pixel));
                if (data[39:32] !== e.left)  report("box_left", 64'(data[39:32]), 64'(e.left));
                if (data[47:40] !== e.top)   report("box_top", 64'(data[47:40]), 64'(e.top));
                if (data[56:48] !== e.width) report("box_width", 64'(data[56:48]), 64'(e.width));
                if (data[65:57] !== e.height) begin
                    report("box_height", 64'(data[65:57]), 64'(e.height));
                end
                if (data[71:66] !== 6'd0)    report("tdata padding", 64'(data[71:66]), 64'd0);
                if (last !== e.last)         report("last_of_crop", 64'(last), 64'(e.last));
                if (empty !== e.empty)       report("empty_frame", 64'(empty), 64'(e.empty));
            end
        endtask
    endclass

    // ---------------------------------------------------------------- DUT side signals
    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [cbb_pkg::CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [cbb_pkg::CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                            s_axis_tvalid = 1'b0;
    wire                             s_axis_tready;
    logic [cbb_pkg::PIX_W-1:0]       s_axis_tdata  = '0;   // [31:0] pixel_in
    logic [0:0]                      s_axis_tuser  = '0;   // [0] command
    wire                             m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [31:0] pixel_out, [39:32] box_left, [47:40] box_top,
    // [56:48] box_width, [65:57] box_height, [71:66] zero
    wire [cbb_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    wire                             m_axis_tlast;         // last_of_crop
    wire [0:0]                       m_axis_tuser;         // [0] empty_frame

    crop_scoreboard sb = new();

    bit steady       = 1'b0;   // both sides stop idling while set
    bit hold_off_req = 1'b0;   // asks the receiver for one long hold-off
    int items_sent   = 0;
    int cycle_count  = 0;

    content_bounding_box_autocrop_core i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a lost result or a stuck handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result monitor: values seen right at the edge are the pre-edge ones, since
    // both the block and the testbench update through nonblocking assignments.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_output(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
        end
    end

    // Result sink: random back-pressure, plus one long hold-off on request.
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= GAP_PCT);
            end
        end
    end

    // ---------------------------------------------------------------- command driver
    // Offers one command and returns at its transfer edge; tvalid stays high so that
    // back-to-back commands keep streaming without a bubble.
    task automatic offer_item(cbb_pkg::t_cmd cmd, logic [cbb_pkg::PIX_W-1:0] px);
        if (!steady && $urandom_range(99) < GAP_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(cmd, px);
        items_sent++;
    endtask

    // Drain all read results, then let the pipeline settle before touching registers.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one write, then the enable is dropped before the task returns
    task automatic write_reg(logic [cbb_pkg::CFG_IDX_W-1:0] idx,
                             logic [cbb_pkg::CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.note_config(idx, value);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(logic [8:0] w, logic [8:0] h, logic [2:0] chans);
        wait_idle();
        write_reg(cbb_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(cbb_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(cbb_pkg::CFG_CHANNEL_COUNT, 9'(chans));
    endtask

    // White pixels carry random upper bytes; content pixels any channel-0 value but 255.
    function automatic logic [cbb_pkg::PIX_W-1:0] pick_pixel(int content_pct);
        logic [cbb_pkg::PIX_W-1:0] px;
        px = $urandom();
        if ($urandom_range(99) < content_pct) begin
            if (px[7:0] == cbb_pkg::WHITE_LEVEL) px[7:0] = 8'($urandom_range(254, 0));
        end else begin
            px[7:0] = cbb_pkg::WHITE_LEVEL;
        end
        return px;
    endfunction

    // Loads until the load position wraps back to the origin.
    task automatic load_frame(int content_pct);
        do offer_item(cbb_pkg::CMD_LOAD, pick_pixel(content_pct)); while (!sb.at_origin());
    endtask

    // A partial frame or a geometry change leaves no complete frame: load until one is.
    task automatic load_full_frame(int content_pct);
        do load_frame(content_pct); while (!sb.frame_ready);
    endtask

    // White frame with a single content pixel; starts at the origin.
    task automatic load_marked_frame(int mark_col, int mark_row);
        logic [cbb_pkg::PIX_W-1:0] px;
        do begin
            px = pick_pixel(0);
            if (sb.ld_col == mark_col && sb.ld_row == mark_row) px[7:0] = 8'h00;
            offer_item(cbb_pkg::CMD_LOAD, px);
        end while (!sb.at_origin());
    endtask

    task automatic read_crop(int count);
        repeat (count) offer_item(cbb_pkg::CMD_READ, $urandom());
    endtask

    function automatic int pick_density();
        case ($urandom_range(3))
            0:       return 3;
            1:       return 20;
            2:       return 60;
            default: return 100;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus
    initial begin : stimulus
        logic [cbb_pkg::PIX_W-1:0] directed_px [6];
        logic [8:0]                w, h;
        int                        phase_no, kind, n, base;

        directed_px = '{32'hDEAD_BEFF, 32'h1234_5600, 32'h8000_00FF,
                        32'hFFFF_FFFF, 32'h0000_00FF, 32'hA5C3_E7FE};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part
        // nothing loaded yet: the box is empty, so reads answer with the empty flag
        read_crop(2);

        // 3 x 2 frame, content at (1,0) with channel 0 of zero and at (2,1) near-white (254):
        // box is columns 1..2, rows 0..1; five reads wrap past the last pixel
        set_geometry(9'd3, 9'd2, 3'd4);
        foreach (directed_px[i]) offer_item(cbb_pkg::CMD_LOAD, directed_px[i]);
        read_crop(5);

        // channel count 1, then the out-of-range settings 0 and 7, then 2
        wait_idle();
        write_reg(cbb_pkg::CFG_CHANNEL_COUNT, 9'd1);
        read_crop(2);
        wait_idle();
        write_reg(cbb_pkg::CFG_CHANNEL_COUNT, 9'd0);
        read_crop(1);
        wait_idle();
        write_reg(cbb_pkg::CFG_CHANNEL_COUNT, 9'd7);
        read_crop(1);
        wait_idle();
        write_reg(cbb_pkg::CFG_CHANNEL_COUNT, 9'd2);
        read_crop(1);

        // all-white frame
        load_frame(0);
        read_crop(2);

        // zero width and height act as a 1 x 1 frame
        set_geometry(9'd0, 9'd0, 3'd3);
        load_frame(100);
        read_crop(2);

        // --- size extreme
        // 511 wide clamps to 256; the only content pixel sits at the far right column.
        // The sink holds off meanwhile, so the block fills up and stops taking reads.
        set_geometry(9'd511, 9'd1, 3'd4);
        load_marked_frame(255, 0);
        hold_off_req = 1'b1;
        read_crop(24);

        // --- random part: mostly load-a-frame-then-crop, some noise and odd geometry
        base     = items_sent;
        phase_no = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            steady = (phase_no >= 1 && phase_no < 3);
            kind   = $urandom_range(9);

            w = ($urandom_range(15) == 0) ? 9'd0 : 9'($urandom_range(8, 1));
            h = ($urandom_range(15) == 0) ? 9'd0 : 9'($urandom_range(4, 1));

            if (kind <= 5) begin
                set_geometry(w, h, 3'($urandom_range(7)));
                load_full_frame(pick_density());
                n = $urandom_range(2 * sb.box_area() + 1, 1);
                read_crop((n > 300) ? 300 : n);
            end else if (kind == 6) begin
                // mixed commands; loads land anywhere in the frame
                repeat (20) begin
                    if (sb.read_safe() && $urandom_range(1) == 1) begin
                        offer_item(cbb_pkg::CMD_READ, $urandom());
                    end else begin
                        offer_item(cbb_pkg::CMD_LOAD, pick_pixel(30));
                    end
                end
            end else if (kind == 7) begin
                // geometry changed in the middle of a frame
                set_geometry(9'($urandom_range(8, 1)), 9'($urandom_range(5, 1)), 3'd4);
                load_full_frame(30);
                repeat ($urandom_range(6, 1)) offer_item(cbb_pkg::CMD_LOAD, pick_pixel(30));
                wait_idle();
                write_reg(cbb_pkg::CFG_IMAGE_WIDTH, 9'($urandom_range(8, 1)));
                write_reg(cbb_pkg::CFG_IMAGE_HEIGHT, 9'($urandom_range(5, 1)));
                load_full_frame(30);
                read_crop($urandom_range(2 * sb.box_area() + 1, 1));
            end else if (kind == 8) begin
                // channel count only; box and store stay as they are
                wait_idle();
                write_reg(cbb_pkg::CFG_CHANNEL_COUNT, 9'($urandom_range(7)));
                if (sb.read_safe()) read_crop($urandom_range(8, 1));
            end else begin
                set_geometry(w, h, 3'($urandom_range(7)));
                load_full_frame(0);
                read_crop($urandom_range(3, 1));
            end
            phase_no++;
        end
        steady = 1'b0;

        // --- wrap-up
        wait_idle();
        if (sb.pending.size() != 0) begin
            sb.report("results never returned", 64'(sb.pending.size()), 64'd0);
        end

        $display("run covered %0d loads in %0d complete frames and %0d crop reads",
                 sb.loads, sb.frames, sb.reads);
        $display("%0d results compared, %0d mismatches, %0d cycles",
                 sb.checked, sb.mismatches, cycle_count);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[content_bounding_box_autocrop_core.f]
+incdir+hdl
hdl/cbb_pkg.sv
hdl/cbb_ram.sv
hdl/cbb_load.sv
hdl/cbb_read.sv
hdl/content_bounding_box_autocrop_core.sv
tb/sv/content_bounding_box_autocrop_core_tb.sv
